[sv/cse_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and reset constants for the charge state estimator.
// No dependencies; every other file of the block refers to this package.
package cse_pkg;

    localparam int MV_W      = 13;
    localparam int THR_W     = 8;
    localparam int CNT_W     = 4;
    localparam int EMA_SHIFT = 3;

    typedef logic [MV_W-1:0]  mv_t;
    typedef logic [THR_W-1:0] thr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam thr_t CLIMB_RESET   = thr_t'(10);
    localparam mv_t  FULL_RESET    = mv_t'(4190);
    localparam thr_t DROP_RESET    = thr_t'(6);
    localparam cnt_t CONFIRM_RESET = cnt_t'(3);

    typedef enum logic [1:0] {
        CFG_CLIMB   = 2'd0,
        CFG_FULL    = 2'd1,
        CFG_DROP    = 2'd2,
        CFG_CONFIRM = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_CHARGING = 2'd1,
        ST_FULL     = 2'd2
    } state_t;

    typedef struct packed {
        thr_t climb;
        mv_t  full;
        thr_t drop;
        cnt_t confirm;
    } cfg_t;

    typedef struct packed {
        mv_t    smoothed;
        mv_t    anchor;
        state_t state;
        cnt_t   agree;
    } est_t;

endpackage

[sv/cse_update.sv]
`timescale 1ns / 1ps
// Combinational update of the estimator for one sample: average, state rules
// and confirmation counter. Depends on cse_pkg.
module cse_update
(
    input  cse_pkg::mv_t  sample,
    input  cse_pkg::est_t cur,
    input  cse_pkg::cfg_t cfg,
    output cse_pkg::est_t nxt,
    output logic          changed
);

    cse_pkg::mv_t     ema;
    cse_pkg::mv_t     diff;
    logic [cse_pkg::MV_W:0] climb_level;
    logic [cse_pkg::MV_W:0] drop_level;
    cse_pkg::state_t  target;
    cse_pkg::cnt_t    agree_inc;

    always_comb
    begin
        if (sample >= cur.smoothed)
        begin
            diff = sample - cur.smoothed;
            ema  = cur.smoothed + (diff >> cse_pkg::EMA_SHIFT);
        end
        else
        begin
            diff = cur.smoothed - sample;
            ema  = cur.smoothed - (diff >> cse_pkg::EMA_SHIFT);
        end
    end

    assign climb_level = {1'b0, cur.anchor} + {{(cse_pkg::MV_W - cse_pkg::THR_W + 1){1'b0}}, cfg.climb};
    assign drop_level  = {1'b0, ema} + {{(cse_pkg::MV_W - cse_pkg::THR_W + 1){1'b0}}, cfg.drop};
    assign agree_inc   = cur.agree + cse_pkg::cnt_t'(1);

    always_comb
    begin
        nxt     = cur;
        changed = 1'b0;
        target  = cur.state;
        if (cur.smoothed == '0)
        begin
            nxt.smoothed = sample;
            nxt.anchor   = sample;
        end
        else
        begin
            nxt.smoothed = ema;
            unique case (cur.state)
                cse_pkg::ST_IDLE:
                begin
                    if ({1'b0, ema} >= climb_level)
                    begin
                        target = cse_pkg::ST_CHARGING;
                    end
                    else if (ema < cur.anchor)
                    begin
                        nxt.anchor = ema;
                    end
                end
                cse_pkg::ST_CHARGING:
                begin
                    if (ema >= cfg.full)
                    begin
                        target = cse_pkg::ST_FULL;
                    end
                    else if (ema <= cur.anchor)
                    begin
                        target = cse_pkg::ST_IDLE;
                    end
                end
                cse_pkg::ST_FULL:
                begin
                    if (drop_level <= {1'b0, cfg.full})
                    begin
                        target = cse_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    target = cur.state;
                end
            endcase

            if (target == cur.state)
            begin
                nxt.agree = '0;
            end
            else
            begin
                nxt.agree = agree_inc;
                if ((agree_inc >= cfg.confirm) || (agree_inc == '0))
                begin
                    nxt.agree  = '0;
                    nxt.anchor = ema;
                    nxt.state  = target;
                    changed    = 1'b1;
                end
            end
        end
    end

endmodule

[sv/charge_state_estimator_top.sv]
`timescale 1ns / 1ps
// Top level of the charge state estimator: configuration registers, state
// registers and the result register. Depends on cse_pkg and cse_update.
// A sample's result is registered when the sample is transferred and held in
// the result register until it is taken. Throughput is one sample per cycle
// while out_ready is high; the result register is the only stage.
// Reset clears the estimator state, loads the default configuration and
// empties the result register.
module charge_state_estimator_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cse_pkg::mv_t         sample_mv,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           charge_state,
    output logic                 changed,
    output logic [1:0]           previous_state,
    output cse_pkg::mv_t         smoothed_mv,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [cse_pkg::MV_W-1:0] cfg_data
);

    cse_pkg::cfg_t   cfg_reg;
    cse_pkg::est_t   est_reg;
    cse_pkg::est_t   est_next;
    logic            changed_next;
    logic            out_valid_reg;
    logic [1:0]      charge_state_reg;
    logic            changed_reg;
    logic [1:0]      previous_state_reg;
    cse_pkg::mv_t    smoothed_reg;
    logic            in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    cse_update u_update
    (
        .sample  (sample_mv),
        .cur     (est_reg),
        .cfg     (cfg_reg),
        .nxt     (est_next),
        .changed (changed_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.climb   <= cse_pkg::CLIMB_RESET;
            cfg_reg.full    <= cse_pkg::FULL_RESET;
            cfg_reg.drop    <= cse_pkg::DROP_RESET;
            cfg_reg.confirm <= cse_pkg::CONFIRM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cse_pkg::cfg_idx_t'(cfg_index))
                cse_pkg::CFG_CLIMB:   cfg_reg.climb   <= cfg_data[cse_pkg::THR_W-1:0];
                cse_pkg::CFG_FULL:    cfg_reg.full    <= cfg_data;
                cse_pkg::CFG_DROP:    cfg_reg.drop    <= cfg_data[cse_pkg::THR_W-1:0];
                cse_pkg::CFG_CONFIRM: cfg_reg.confirm <= cfg_data[cse_pkg::CNT_W-1:0];
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg.smoothed <= '0;
            est_reg.anchor   <= '0;
            est_reg.state    <= cse_pkg::ST_IDLE;
            est_reg.agree    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                est_reg       <= est_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            charge_state_reg   <= est_next.state;
            changed_reg        <= changed_next;
            previous_state_reg <= est_reg.state;
            smoothed_reg       <= est_next.smoothed;
        end
    end

    assign out_valid      = out_valid_reg;
    assign charge_state   = charge_state_reg;
    assign changed        = changed_reg;
    assign previous_state = previous_state_reg;
    assign smoothed_mv    = smoothed_reg;

    // An unseeded filter never leaves idle or counts disagreeing samples.
    a_unseeded_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (est_reg.smoothed == '0) |-> (est_reg.state == cse_pkg::ST_IDLE && est_reg.agree == '0))
        else $error("unseeded filter with non-idle state or counter");

    a_changed_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> (charge_state_reg != previous_state_reg))
        else $error("committed change reports the same state");

    a_unchanged_same: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !changed_reg) |-> (charge_state_reg == previous_state_reg))
        else $error("result without change reports a different previous state");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && changed_next) |=> (est_reg.agree == '0 && est_reg.anchor == est_reg.smoothed))
        else $error("commit did not clear the counter or reset the anchor");

endmodule
